// ----- rtl/gyro_deadband_angle_integrator_macros.svh -----
// assertion macros shared by the gyro angle integrator
`ifndef GYRO_DEADBAND_ANGLE_INTEGRATOR_MACROS_SVH
`define GYRO_DEADBAND_ANGLE_INTEGRATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define GDAI_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("gdai assertion failed");

// next-cycle implication, checked outside reset
`define GDAI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("gdai assertion failed");

`endif

// ----- rtl/gdai_pkg.sv -----
// shared types and constants for the gyro angle integrator
package gdai_pkg;

	localparam int RATE_W    = 16;
	localparam int ANGLE_W   = 16;
	localparam int DB_W      = 16;
	localparam int SCALE_W   = 32;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int PROD_W    = 64;

	localparam logic [DB_W-1:0]    RP_DB_RST  = 16'd100;
	localparam logic [DB_W-1:0]    YAW_DB_RST = 16'd10;
	localparam logic [SCALE_W-1:0] SCALE_RST  = 32'd257698;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RP_DB     = 3'd0,
		CFG_YAW_DB    = 3'd1,
		CFG_ROLL_OFF  = 3'd2,
		CFG_PITCH_OFF = 3'd3,
		CFG_YAW_OFF   = 3'd4,
		CFG_SCALE     = 3'd5
	} cfg_index_t;

	// stage load enables for the scaling pipeline
	typedef struct packed {
		logic s2_en;
		logic s3_en;
		logic out_en;
	} pipe_ctrl_t;

endpackage

// ----- rtl/gdai_acc.sv -----
// per-axis drift correction, deadband gate and saturating accumulator
module gdai_acc #(
	parameter int SUM_WIDTH = 48
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               load,
	input  logic signed [gdai_pkg::RATE_W-1:0] rate,
	input  logic signed [gdai_pkg::RATE_W-1:0] offset,
	input  logic        [gdai_pkg::DB_W-1:0]   deadband,
	output logic signed [SUM_WIDTH-1:0]        sum
);
	import gdai_pkg::*;

	logic signed [RATE_W:0]      corr;
	logic        [RATE_W:0]      corr_mag;
	logic signed [RATE_W:0]      delta;
	logic signed [SUM_WIDTH:0]   sum_ext;
	logic signed [SUM_WIDTH-1:0] sum_next;
	logic signed [SUM_WIDTH-1:0] sum_q;

	// corrected rate at 17 bits, never wraps
	assign corr     = (RATE_W+1)'(rate) + (RATE_W+1)'(offset);
	assign corr_mag = corr[RATE_W] ? ((RATE_W+1)'(0) - corr) : corr;
	assign delta    = (corr_mag < {1'b0, deadband}) ? '0 : corr;

	// saturating add: overflow shows as differing top two bits
	assign sum_ext = (SUM_WIDTH+1)'(sum_q) + (SUM_WIDTH+1)'(delta);
	always_comb begin
		if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
			sum_next = {sum_ext[SUM_WIDTH], {(SUM_WIDTH-1){~sum_ext[SUM_WIDTH]}}};
		end else begin
			sum_next = sum_ext[SUM_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (load) begin
			sum_q <= sum_next;
		end
	end

	assign sum = sum_q;

endmodule

// ----- rtl/gdai_scale.sv -----
// sum times Q0.32 scale in two partial products, then round or truncate and clamp
module gdai_scale #(
	parameter int SUM_WIDTH = 48
) (
	input  logic                                clk,
	input  gdai_pkg::pipe_ctrl_t                ctrl,
	input  logic                                round_half,
	input  logic signed [SUM_WIDTH-1:0]         sum,
	input  logic        [gdai_pkg::SCALE_W-1:0] scale,
	output logic signed [gdai_pkg::ANGLE_W-1:0] angle
);
	import gdai_pkg::*;

	logic [SUM_WIDTH-1:0]     mag;
	logic                     neg_s2;
	logic [PROD_W-1:0]        mag_s2;
	logic                     neg_s3;
	logic [PROD_W-1:0]        lo_s3;
	logic [PROD_W-1:0]        hi_s3;
	logic [PROD_W-1:0]        ip;
	logic signed [ANGLE_W-1:0] angle_next;
	logic signed [ANGLE_W-1:0] angle_q;

	// magnitude of the sum; the most negative value maps to 2^(SUM_WIDTH-1)
	assign mag = sum[SUM_WIDTH-1] ? (SUM_WIDTH'(0) - sum) : sum;

	always_ff @(posedge clk) begin
		if (ctrl.s2_en) begin
			neg_s2 <= sum[SUM_WIDTH-1];
			mag_s2 <= PROD_W'(mag);
		end
	end

	// two 32x32 partial products
	always_ff @(posedge clk) begin
		if (ctrl.s3_en) begin
			neg_s3 <= neg_s2;
			lo_s3  <= PROD_W'(mag_s2[31:0]) * PROD_W'(scale);
			hi_s3  <= PROD_W'(mag_s2[63:32]) * PROD_W'(scale);
		end
	end

	// integer part with optional round up on the top fraction bit
	assign ip = hi_s3 + {32'd0, lo_s3[63:32]} + PROD_W'(round_half & lo_s3[31]);

	// apply sign and clamp to 16 bits
	always_comb begin
		if (neg_s3) begin
			angle_next = (ip > PROD_W'(32768)) ? 16'sh8000 : (16'sd0 - ip[ANGLE_W-1:0]);
		end else begin
			angle_next = (ip > PROD_W'(32767)) ? 16'sh7fff : ip[ANGLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_en) begin
			angle_q <= angle_next;
		end
	end

	assign angle = angle_q;

endmodule

// ----- rtl/gyro_deadband_angle_integrator.sv -----
// Gyro rate integrator: drift offset, deadband, saturating sums, scaled angles.
// Stages: each item passes the sum, magnitude, product and output registers in turn.
// Throughput: one item per cycle while angle_stall is low; the sum-by-scale multiply is
// split into two 32x32 partial products, both formed in the product stage.
// Reset clears the three sums, empties the pipeline and loads register defaults.
module gyro_deadband_angle_integrator #(
	parameter int SUM_WIDTH = 48
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_write,
	input  logic [gdai_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [gdai_pkg::CFG_W-1:0]            cfg_data,
	// rate input channel
	input  logic                                  rate_valid,
	output logic                                  rate_stall,
	input  logic signed [gdai_pkg::RATE_W-1:0]    roll_rate,
	input  logic signed [gdai_pkg::RATE_W-1:0]    pitch_rate,
	input  logic signed [gdai_pkg::RATE_W-1:0]    yaw_rate,
	// angle output channel
	output logic                                  angle_valid,
	input  logic                                  angle_stall,
	output logic signed [gdai_pkg::ANGLE_W-1:0]   roll_angle,
	output logic signed [gdai_pkg::ANGLE_W-1:0]   pitch_angle,
	output logic signed [gdai_pkg::ANGLE_W-1:0]   yaw_angle
);
	import gdai_pkg::*;

`include "gyro_deadband_angle_integrator_macros.svh"

	logic [DB_W-1:0]          rp_db_q;
	logic [DB_W-1:0]          yaw_db_q;
	logic signed [RATE_W-1:0] roll_off_q;
	logic signed [RATE_W-1:0] pitch_off_q;
	logic signed [RATE_W-1:0] yaw_off_q;
	logic [SCALE_W-1:0]       scale_q;

	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic angle_valid_q;
	logic s1_en;
	logic accept;
	pipe_ctrl_t ctrl;

	logic signed [SUM_WIDTH-1:0] roll_sum;
	logic signed [SUM_WIDTH-1:0] pitch_sum;
	logic signed [SUM_WIDTH-1:0] yaw_sum;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_db_q     <= RP_DB_RST;
			yaw_db_q    <= YAW_DB_RST;
			roll_off_q  <= '0;
			pitch_off_q <= '0;
			yaw_off_q   <= '0;
			scale_q     <= SCALE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_RP_DB:     rp_db_q     <= cfg_data[DB_W-1:0];
				CFG_YAW_DB:    yaw_db_q    <= cfg_data[DB_W-1:0];
				CFG_ROLL_OFF:  roll_off_q  <= cfg_data[RATE_W-1:0];
				CFG_PITCH_OFF: pitch_off_q <= cfg_data[RATE_W-1:0];
				CFG_YAW_OFF:   yaw_off_q   <= cfg_data[RATE_W-1:0];
				CFG_SCALE:     scale_q     <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// stage enables: a stage loads when empty or when the next one moves
	assign ctrl.out_en = !angle_valid_q || !angle_stall;
	assign ctrl.s3_en  = !v_s3 || ctrl.out_en;
	assign ctrl.s2_en  = !v_s2 || ctrl.s3_en;
	assign s1_en       = !v_s1 || ctrl.s2_en;
	assign rate_stall  = !s1_en;
	assign accept      = rate_valid && s1_en;

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			angle_valid_q <= 1'b0;
		end else begin
			if (s1_en) begin
				v_s1 <= rate_valid;
			end
			if (ctrl.s2_en) begin
				v_s2 <= v_s1;
			end
			if (ctrl.s3_en) begin
				v_s3 <= v_s2;
			end
			if (ctrl.out_en) begin
				angle_valid_q <= v_s3;
			end
		end
	end

	assign angle_valid = angle_valid_q;

	// accumulators, updated on each accepted item
	gdai_acc #(.SUM_WIDTH(SUM_WIDTH)) u_roll_acc (
		.clk(clk), .arst_n(arst_n), .load(accept),
		.rate(roll_rate), .offset(roll_off_q), .deadband(rp_db_q), .sum(roll_sum)
	);
	gdai_acc #(.SUM_WIDTH(SUM_WIDTH)) u_pitch_acc (
		.clk(clk), .arst_n(arst_n), .load(accept),
		.rate(pitch_rate), .offset(pitch_off_q), .deadband(rp_db_q), .sum(pitch_sum)
	);
	gdai_acc #(.SUM_WIDTH(SUM_WIDTH)) u_yaw_acc (
		.clk(clk), .arst_n(arst_n), .load(accept),
		.rate(yaw_rate), .offset(yaw_off_q), .deadband(yaw_db_q), .sum(yaw_sum)
	);

	// angle scaling; yaw rounds, roll and pitch truncate
	gdai_scale #(.SUM_WIDTH(SUM_WIDTH)) u_roll_scale (
		.clk(clk), .ctrl(ctrl), .round_half(1'b0),
		.sum(roll_sum), .scale(scale_q), .angle(roll_angle)
	);
	gdai_scale #(.SUM_WIDTH(SUM_WIDTH)) u_pitch_scale (
		.clk(clk), .ctrl(ctrl), .round_half(1'b0),
		.sum(pitch_sum), .scale(scale_q), .angle(pitch_angle)
	);
	gdai_scale #(.SUM_WIDTH(SUM_WIDTH)) u_yaw_scale (
		.clk(clk), .ctrl(ctrl), .round_half(1'b1),
		.sum(yaw_sum), .scale(scale_q), .angle(yaw_angle)
	);

	// roll and yaw sums move only on an accepted item
	`GDAI_ASSERT_NEXT(a_sum_hold, clk, arst_n, !accept, $stable(roll_sum) && $stable(yaw_sum))
	// input stalls only when every stage holds an item behind a stalled output
	`GDAI_ASSERT_IMPLY(a_stall_full, clk, arst_n, rate_stall, v_s1 && v_s2 && v_s3 && angle_valid_q && angle_stall)
	// a delivered result with nothing behind it leaves the output empty
	`GDAI_ASSERT_NEXT(a_drain, clk, arst_n, angle_valid_q && !angle_stall && !v_s3, !angle_valid_q)

endmodule

// ----- verif/gyro_angle_checker.sv -----
// checker for the gyro angle integrator: watches both channels, predicts angles, compares
module gyro_angle_checker #(
	parameter int SUM_WIDTH = 48
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [gdai_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [gdai_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                  rate_valid,
	input  logic                                  rate_stall,
	input  logic signed [gdai_pkg::RATE_W-1:0]    roll_rate,
	input  logic signed [gdai_pkg::RATE_W-1:0]    pitch_rate,
	input  logic signed [gdai_pkg::RATE_W-1:0]    yaw_rate,
	input  logic                                  angle_valid,
	input  logic                                  angle_stall,
	input  logic signed [gdai_pkg::ANGLE_W-1:0]   roll_angle,
	input  logic signed [gdai_pkg::ANGLE_W-1:0]   pitch_angle,
	input  logic signed [gdai_pkg::ANGLE_W-1:0]   yaw_angle,
	output int                                    fail_count,
	output int                                    pending
);
	import gdai_pkg::*;

	localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 16'sh7fff;
	localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = 16'sh8000;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] roll;
		logic signed [ANGLE_W-1:0] pitch;
		logic signed [ANGLE_W-1:0] yaw;
	} angles_t;

	angles_t angles_due[$];
	angles_t next_angles;
	angles_t oldest;

	// predictor copy of the registers and the three sums
	logic [DB_W-1:0]              rp_db;
	logic [DB_W-1:0]              yaw_db;
	logic signed [RATE_W-1:0]     roll_off;
	logic signed [RATE_W-1:0]     pitch_off;
	logic signed [RATE_W-1:0]     yaw_off;
	logic [SCALE_W-1:0]           scale;
	logic signed [SUM_WIDTH-1:0]  roll_sum;
	logic signed [SUM_WIDTH-1:0]  pitch_sum;
	logic signed [SUM_WIDTH-1:0]  yaw_sum;

	// drift-corrected rate at 17 bits, zero when its magnitude is under the deadband
	function automatic logic signed [RATE_W:0] gated_rate(logic signed [RATE_W-1:0] rate,
			logic signed [RATE_W-1:0] off, logic [DB_W-1:0] db);
		logic signed [RATE_W:0] fixed;
		logic [RATE_W:0]        mag;
		fixed = rate + off;
		mag = fixed[RATE_W] ? -fixed : fixed;
		return (mag < {1'b0, db}) ? '0 : fixed;
	endfunction

	// accumulate with clamping at the signed limits of the sum
	function automatic logic signed [SUM_WIDTH-1:0] saturating_sum(
			logic signed [SUM_WIDTH-1:0] s, logic signed [RATE_W:0] d);
		logic signed [SUM_WIDTH:0] wide;
		wide = s + d;
		if (wide[SUM_WIDTH] != wide[SUM_WIDTH-1])
			return wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}} : {1'b0, {(SUM_WIDTH-1){1'b1}}};
		return wide[SUM_WIDTH-1:0];
	endfunction

	// magnitude times Q0.32 scale, optional round half away from zero, clamp to 16 bits
	function automatic logic signed [ANGLE_W-1:0] scaled_angle(logic signed [SUM_WIDTH-1:0] s,
			logic [SCALE_W-1:0] k, bit round_half);
		logic [SUM_WIDTH-1:0]         mag;
		logic [SUM_WIDTH+SCALE_W-1:0] prod;
		logic [SUM_WIDTH-1:0]         whole;
		mag = s[SUM_WIDTH-1] ? -s : s;
		prod = mag * k;
		whole = prod[SUM_WIDTH+SCALE_W-1:SCALE_W];
		if (round_half && prod[SCALE_W-1])
			whole = whole + 1'b1;
		if (s[SUM_WIDTH-1])
			return (whole > 32768) ? ANGLE_MIN : -whole[ANGLE_W-1:0];
		return (whole > 32767) ? ANGLE_MAX : whole[ANGLE_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_db = RP_DB_RST;
			yaw_db = YAW_DB_RST;
			roll_off = '0;
			pitch_off = '0;
			yaw_off = '0;
			scale = SCALE_RST;
			roll_sum = '0;
			pitch_sum = '0;
			yaw_sum = '0;
			angles_due.delete();
			fail_count = 0;
		end else begin
			// register writes, out-of-range indexes are dropped
			if (cfg_write) begin
				case (cfg_index)
					CFG_RP_DB:     rp_db = cfg_data[DB_W-1:0];
					CFG_YAW_DB:    yaw_db = cfg_data[DB_W-1:0];
					CFG_ROLL_OFF:  roll_off = cfg_data[RATE_W-1:0];
					CFG_PITCH_OFF: pitch_off = cfg_data[RATE_W-1:0];
					CFG_YAW_OFF:   yaw_off = cfg_data[RATE_W-1:0];
					CFG_SCALE:     scale = cfg_data[SCALE_W-1:0];
					default: ;
				endcase
			end

			// compare an accepted angle item against the oldest prediction
			if (angle_valid && !angle_stall) begin
				if (angles_due.size() == 0) begin
					$error("angle item with no rate item outstanding");
					fail_count++;
				end else begin
					oldest = angles_due.pop_front();
					if (roll_angle !== oldest.roll) begin
						$error("roll_angle: expected %0d, got %0d", oldest.roll, roll_angle);
						fail_count++;
					end
					if (pitch_angle !== oldest.pitch) begin
						$error("pitch_angle: expected %0d, got %0d", oldest.pitch, pitch_angle);
						fail_count++;
					end
					if (yaw_angle !== oldest.yaw) begin
						$error("yaw_angle: expected %0d, got %0d", oldest.yaw, yaw_angle);
						fail_count++;
					end
				end
			end

			// integrate an accepted rate item and queue its angles
			if (rate_valid && !rate_stall) begin
				roll_sum = saturating_sum(roll_sum, gated_rate(roll_rate, roll_off, rp_db));
				pitch_sum = saturating_sum(pitch_sum, gated_rate(pitch_rate, pitch_off, rp_db));
				yaw_sum = saturating_sum(yaw_sum, gated_rate(yaw_rate, yaw_off, yaw_db));
				next_angles.roll = scaled_angle(roll_sum, scale, 1'b0);
				next_angles.pitch = scaled_angle(pitch_sum, scale, 1'b0);
				next_angles.yaw = scaled_angle(yaw_sum, scale, 1'b1);
				angles_due.push_back(next_angles);
			end
		end
		pending = angles_due.size();
	end

endmodule

// ----- verif/tb_gyro_deadband_angle_integrator.sv -----
// testbench top for the gyro angle integrator: stimulus, stalls, register phases, verdict
module tb_gyro_deadband_angle_integrator;
	import gdai_pkg::*;

	localparam int ITEMS_PER_PHASE = 170;
	localparam int SETTLE_CYCLES   = 8;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int NUM_REGS        = 6;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_write;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_W-1:0]          cfg_data;
	logic                      rate_valid;
	logic                      rate_stall;
	logic signed [RATE_W-1:0]  roll_rate;
	logic signed [RATE_W-1:0]  pitch_rate;
	logic signed [RATE_W-1:0]  yaw_rate;
	logic                      angle_valid;
	logic                      angle_stall;
	logic signed [ANGLE_W-1:0] roll_angle;
	logic signed [ANGLE_W-1:0] pitch_angle;
	logic signed [ANGLE_W-1:0] yaw_angle;
	int                        fail_count;
	int                        pending;
	int                        cycles = 0;
	bit                        steady_flow;
	logic [CFG_W-1:0]          cfg_shadow [NUM_REGS];

	gyro_deadband_angle_integrator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.rate_valid  (rate_valid),
		.rate_stall  (rate_stall),
		.roll_rate   (roll_rate),
		.pitch_rate  (pitch_rate),
		.yaw_rate    (yaw_rate),
		.angle_valid (angle_valid),
		.angle_stall (angle_stall),
		.roll_angle  (roll_angle),
		.pitch_angle (pitch_angle),
		.yaw_angle   (yaw_angle)
	);

	gyro_angle_checker angle_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.rate_valid  (rate_valid),
		.rate_stall  (rate_stall),
		.roll_rate   (roll_rate),
		.pitch_rate  (pitch_rate),
		.yaw_rate    (yaw_rate),
		.angle_valid (angle_valid),
		.angle_stall (angle_stall),
		.roll_angle  (roll_angle),
		.pitch_angle (pitch_angle),
		.yaw_angle   (yaw_angle),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// angle side: random stall before each item, none in steady stretches
	initial begin
		int hold;
		angle_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			hold = steady_flow ? 0 : $urandom_range(0, 9);
			if (hold > 0) begin
				angle_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			angle_stall <= 1'b0;
			do @(posedge clk); while (angle_valid !== 1'b1);
		end
	end

	// one rate item, after a random gap (none in steady stretches), held until taken
	task automatic send_rates(logic [RATE_W-1:0] r, logic [RATE_W-1:0] p, logic [RATE_W-1:0] y);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			rate_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rate_valid <= 1'b1;
		roll_rate <= r;
		pitch_rate <= p;
		yaw_rate <= y;
		do @(posedge clk); while (rate_stall !== 1'b0);
	endtask

	// mix of full-range, small and deadband-edge rates
	task automatic send_random();
		logic [RATE_W-1:0] v [3];
		int db;
		int off;
		int edge_mag;
		case ($urandom_range(0, 3))
			0: begin
				for (int a = 0; a < 3; a++) begin
					db = (a == 2) ? cfg_shadow[CFG_YAW_DB][DB_W-1:0] : cfg_shadow[CFG_RP_DB][DB_W-1:0];
					off = $signed(cfg_shadow[CFG_ROLL_OFF + a][RATE_W-1:0]);
					edge_mag = db + $urandom_range(0, 2) - 1;
					v[a] = RATE_W'(-off + ($urandom_range(0, 1) ? edge_mag : -edge_mag));
				end
			end
			1: begin
				for (int a = 0; a < 3; a++)
					v[a] = RATE_W'($urandom_range(0, 600) - 300);
			end
			default: begin
				for (int a = 0; a < 3; a++)
					v[a] = RATE_W'($urandom);
			end
		endcase
		send_rates(v[0], v[1], v[2]);
	endtask

	task automatic run_random(int count);
		repeat (count) send_random();
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx < NUM_REGS)
			cfg_shadow[idx] = value;
		@(posedge clk);
	endtask

	// wait for every outstanding angle item, then rewrite all registers
	task automatic set_phase(int rp_db, int yaw_db, int roll_off, int pitch_off, int yaw_off,
			logic [SCALE_W-1:0] scale);
		rate_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		// upper bits of narrow registers carry junk that must be masked off
		write_reg(CFG_RP_DB, {16'($urandom), 16'(rp_db)});
		write_reg(CFG_YAW_DB, {16'($urandom), 16'(yaw_db)});
		write_reg(CFG_ROLL_OFF, {16'($urandom), 16'(roll_off)});
		write_reg(CFG_PITCH_OFF, {16'($urandom), 16'(pitch_off)});
		write_reg(CFG_YAW_OFF, {16'($urandom), 16'(yaw_off)});
		write_reg(CFG_SCALE, scale);
		write_reg(CFG_IDX_SPARE_LO, $urandom);
		write_reg(CFG_IDX_SPARE_HI, $urandom);
		cfg_write <= 1'b0;
		steady_flow = ($urandom_range(0, 3) == 0);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_RP_DB;
		cfg_data = '0;
		rate_valid = 1'b0;
		roll_rate = '0;
		pitch_rate = '0;
		yaw_rate = '0;
		steady_flow = 1'b0;
		cfg_shadow[CFG_RP_DB] = RP_DB_RST;
		cfg_shadow[CFG_YAW_DB] = YAW_DB_RST;
		cfg_shadow[CFG_ROLL_OFF] = '0;
		cfg_shadow[CFG_PITCH_OFF] = '0;
		cfg_shadow[CFG_YAW_OFF] = '0;
		cfg_shadow[CFG_SCALE] = SCALE_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset defaults: deadband edges on both sides and field extremes
		send_rates(16'sd0, 16'sd0, 16'sd0);
		send_rates(16'sd99, -16'sd99, 16'sd9);
		send_rates(16'sd100, -16'sd100, 16'sd10);
		send_rates(-16'sd100, 16'sd100, -16'sd10);
		send_rates(16'sd101, -16'sd101, -16'sd9);
		send_rates(16'sh7fff, 16'sh8000, 16'sh7fff);
		send_rates(16'sh8000, 16'sh7fff, 16'sh8000);
		run_random(ITEMS_PER_PHASE);

		// zero deadband, full scale: angles clamp at both ends
		set_phase(0, 0, 0, 0, 0, 32'hffff_ffff);
		send_rates(16'sd0, 16'sd0, 16'sd0);
		send_rates(16'sd1, -16'sd1, 16'sd1);
		send_rates(16'sh7fff, 16'sh8000, 16'sh7fff);
		send_rates(16'sh8000, 16'sh7fff, 16'sh8000);
		run_random(ITEMS_PER_PHASE);

		// widest deadband, extreme offsets, zero scale
		set_phase(65535, 65535, 32767, -32768, -32768, 32'h0000_0000);
		send_rates(16'sh7fff, 16'sh8000, 16'sh8000);
		send_rates(16'sh8000, 16'sh7fff, 16'sh7fff);
		run_random(ITEMS_PER_PHASE);

		// half scale: odd sums land exactly on the rounding point
		set_phase(0, 0, -32768, 32767, 32767, 32'h8000_0000);
		send_rates(16'sd1, 16'sd1, 16'sd1);
		send_rates(-16'sd1, -16'sd1, -16'sd1);
		send_rates(16'sd3, -16'sd3, 16'sd3);
		run_random(ITEMS_PER_PHASE);

		set_phase(1, 1, 1000, -1000, 20000, 32'h0010_0000);
		run_random(ITEMS_PER_PHASE);

		set_phase($urandom_range(0, 2000), $urandom_range(0, 2000), 16'($urandom), 16'($urandom),
			16'($urandom), $urandom >> $urandom_range(0, 31));
		run_random(ITEMS_PER_PHASE);

		set_phase(RP_DB_RST, YAW_DB_RST, 0, 0, 0, SCALE_RST);
		run_random(ITEMS_PER_PHASE);

		set_phase($urandom_range(0, 2000), $urandom_range(0, 2000), 16'($urandom), 16'($urandom),
			-20000, 32'h8000_0000);
		run_random(ITEMS_PER_PHASE);

		// drain and let the pipeline settle before the verdict
		rate_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
